// ----- design/trm_pkg.sv -----
// shared types, widths and register codes of the threshold marker
package trm_pkg;

  // fixed field widths
  localparam int SAMPLE_W    = 20;
  localparam int THRESH_W    = 19;
  localparam int BEFORE_W    = 5;
  localparam int AFTER_W     = 16;
  localparam int OUT_INDEX_W = 16;
  localparam int ABOVE_W     = 16;
  localparam int REGION_W    = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 19;

  // defaults of the top level parameters
  localparam int MAX_BEFORE_DEF = 31;
  localparam int INDEX_BITS_DEF = 16;

  // entries of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register codes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD     = 3'd0,
    REG_BINS_BEFORE   = 3'd1,
    REG_BINS_AFTER    = 3'd2,
    REG_FLAG_POSITIVE = 3'd3,
    REG_FLAG_NEGATIVE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [BEFORE_W-1:0] bins_before;
    logic [AFTER_W-1:0]  bins_after;
    logic                flag_positive;
    logic                flag_negative;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_channel;
  } in_item_t;

  typedef struct packed {
    logic                   signal_flag;
    logic [OUT_INDEX_W-1:0] sample_index;
    logic [ABOVE_W-1:0]     above_count;
    logic [REGION_W-1:0]    region_count;
    logic                   last_result;
  } out_item_t;

endpackage

// ----- design/trm_queue.sv -----
// small job queue between the classify front and the emit back
module trm_queue
  import trm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_data = entries[rd_ptr];

  // storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no overrun or underrun
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full job queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("pop from empty job queue");

endmodule

// ----- design/trm_front.sv -----
// front: takes samples, tests the threshold, keeps the pre-window and queues emit jobs
module trm_front
  import trm_pkg::*;
#(
  parameter int MAX_BEFORE = MAX_BEFORE_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int JOB_W      = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             job_push,
  output logic [JOB_W-1:0] job_data,
  input  logic             job_full
);

  localparam int PW     = MAX_BEFORE + 1;
  localparam int CNT_W  = $clog2(MAX_BEFORE + 2);
  localparam int FILL_W = (MAX_BEFORE > 1) ? $clog2(MAX_BEFORE + 1) : 1;

  logic [PW-1:0]         pend;
  logic [FILL_W-1:0]     fill;
  logic [AFTER_W-1:0]    after_rem;
  logic [INDEX_BITS-1:0] idx;
  logic [ABOVE_W-1:0]    above;

  logic                     accept;
  logic                     eoc;
  logic signed [SAMPLE_W:0] s_wide;
  logic signed [SAMPLE_W:0] t_wide;
  logic                     keep;
  logic                     cur;
  logic [CNT_W-1:0]         bb;
  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         emit_cnt;
  logic [PW-1:0]            win_set;
  logic [PW-1:0]            pend_cur;
  logic [INDEX_BITS-1:0]    first;
  logic [ABOVE_W-1:0]       above_inc;

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;
  assign eoc      = in_data.end_of_channel;

  // threshold test in a common signed width
  always_comb begin
    s_wide = {in_data.sample_value[SAMPLE_W-1], in_data.sample_value};
    t_wide = $signed({2'b00, cfg.threshold});
    keep   = (cfg.flag_positive && (s_wide > t_wide)) ||
             (cfg.flag_negative && (s_wide < -t_wide));
    cur    = keep || (after_rem != '0);
  end

  // effective pre-window, capped at the buffer size
  always_comb begin
    if (32'(cfg.bins_before) > 32'(MAX_BEFORE)) begin
      bb = CNT_W'(MAX_BEFORE);
    end else begin
      bb = CNT_W'(cfg.bins_before);
    end
  end

  // mark pending samples that lie inside the current pre-window
  always_comb begin
    for (int k = 0; k < PW; k++) begin
      win_set[k] = keep && (k < int'(fill)) && ((k + int'(bb)) >= int'(fill));
    end
  end

  // merge the current flag and work out how many flags leave now
  always_comb begin
    pend_cur  = pend | win_set | (PW'(cur) << fill);
    n         = CNT_W'(fill) + 1'b1;
    if (eoc) begin
      emit_cnt = n;
    end else if (n > bb) begin
      emit_cnt = n - bb;
    end else begin
      emit_cnt = '0;
    end
    first     = idx - INDEX_BITS'(fill);
    above_inc = (keep && (above != '1)) ? above + 1'b1 : above;
  end

  assign job_push = accept && (emit_cnt != '0);
  assign job_data = {pend_cur, emit_cnt, first, above_inc, eoc};

  // channel state, cleared at the end of each channel
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      fill      <= '0;
      after_rem <= '0;
      idx       <= '0;
      above     <= '0;
    end else if (accept) begin
      if (eoc) begin
        pend      <= '0;
        fill      <= '0;
        after_rem <= '0;
        idx       <= '0;
        above     <= '0;
      end else begin
        pend  <= pend_cur >> emit_cnt;
        fill  <= FILL_W'(n - emit_cnt);
        idx   <= idx + 1'b1;
        above <= above_inc;
        if (keep) begin
          after_rem <= cfg.bins_after;
        end else if (after_rem != '0) begin
          after_rem <= after_rem - 1'b1;
        end
      end
    end
  end

  // pending count stays within the buffer
  assert property (@(posedge clk) disable iff (rst) 32'(fill) <= 32'(MAX_BEFORE))
    else $error("pending fill beyond buffer");
  // end of channel leaves a clean state
  assert property (@(posedge clk) disable iff (rst)
      (accept && eoc) |=> (fill == '0 && idx == '0 && pend == '0))
    else $error("channel state not cleared at end of channel");
  // an accepted sample with a full pre-window buffer queues a job
  assert property (@(posedge clk) disable iff (rst)
      (accept && (fill == FILL_W'(MAX_BEFORE))) |-> job_push)
    else $error("full pre-window buffer did not drain");

endmodule

// ----- design/trm_back.sv -----
// back: emits each job's flags, one per cycle while not stalled, with run counts
module trm_back
  import trm_pkg::*;
#(
  parameter int MAX_BEFORE = MAX_BEFORE_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int JOB_W      = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  logic [JOB_W-1:0] job_data,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int PW     = MAX_BEFORE + 1;
  localparam int CNT_W  = $clog2(MAX_BEFORE + 2);
  localparam int FILL_W = (MAX_BEFORE > 1) ? $clog2(MAX_BEFORE + 1) : 1;

  logic [PW-1:0]         j_flags;
  logic [CNT_W-1:0]      j_count;
  logic [INDEX_BITS-1:0] j_first;
  logic [ABOVE_W-1:0]    j_above;
  logic                  j_last;

  logic [CNT_W-1:0]    pos;
  logic [REGION_W-1:0] region;
  logic                prev_flag;

  logic                  can_load;
  logic                  emit;
  logic                  flag;
  logic                  last_in_job;
  logic [INDEX_BITS-1:0] cur_index;
  logic [REGION_W-1:0]   region_upd;
  out_item_t             result;

  assign {j_flags, j_count, j_first, j_above, j_last} = job_data;

  // pick the current flag of the job and count runs
  always_comb begin
    can_load    = !out_valid || !out_stall;
    emit        = job_valid && can_load;
    flag        = j_flags[pos[FILL_W-1:0]];
    last_in_job = (pos == (j_count - 1'b1));
    cur_index   = j_first + INDEX_BITS'(pos);
    region_upd  = (flag && !prev_flag && (region != '1)) ? region + 1'b1 : region;

    result.signal_flag  = flag;
    result.sample_index = OUT_INDEX_W'(cur_index);
    result.above_count  = j_above;
    result.region_count = region_upd;
    result.last_result  = j_last && last_in_job;
  end

  assign job_pop = emit && last_in_job;

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // position in job and run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      region    <= '0;
      prev_flag <= 1'b0;
    end else if (emit) begin
      pos <= last_in_job ? '0 : pos + 1'b1;
      if (j_last && last_in_job) begin
        region    <= '0;
        prev_flag <= 1'b0;
      end else begin
        region    <= region_upd;
        prev_flag <= flag;
      end
    end
  end

  // position never runs past the job
  assert property (@(posedge clk) disable iff (rst) job_valid |-> (pos < j_count))
    else $error("job position past its count");
  // run counters restart after the final flag of a channel
  assert property (@(posedge clk) disable iff (rst)
      (emit && result.last_result) |=> (region == '0 && !prev_flag && pos == '0))
    else $error("run tracking not cleared after channel end");

endmodule

// ----- design/threshold_roi_marker.sv -----
// top level of the threshold marker with pre and post window
//
// Input channel (in_valid, in_stall, in_data) takes one sample of a channel per
// transfer; end_of_channel marks the last sample. Output channel (out_valid,
// out_stall, out_data) gives one signal flag per sample, delayed by the
// pre-window, with its index, the saturating count of samples past threshold
// and the saturating count of signal runs. The last flag of a channel carries
// last_result; the channel state then restarts.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data, ready
// always high; write them only while no sample is in flight.
// Throughput: one sample per cycle in steady state, one result per cycle out.
// A sample that releases k flags (end of channel, or a shortened pre-window)
// occupies the emit unit until all k flags have left; the front keeps accepting
// while the four-entry job queue has room. The first result of a sample passes
// through the job queue and the output register before it is transferred.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall rises once it is full. Reset clears all channel state and sets the
// registers to their defaults (positive mode on, everything else zero).
module threshold_roi_marker
  import trm_pkg::*;
#(
  parameter int MAX_BEFORE = MAX_BEFORE_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW    = MAX_BEFORE + 1;
  localparam int CNT_W = $clog2(MAX_BEFORE + 2);
  localparam int JOB_W = PW + CNT_W + INDEX_BITS + ABOVE_W + 1;

  cfg_t             cfg;
  logic             job_push;
  logic [JOB_W-1:0] job_wdata;
  logic             job_full;
  logic             job_pop;
  logic [JOB_W-1:0] job_rdata;
  logic             job_valid;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= '0;
      cfg.bins_before   <= '0;
      cfg.bins_after    <= '0;
      cfg.flag_positive <= 1'b1;
      cfg.flag_negative <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:     cfg.threshold     <= cfg_data[THRESH_W-1:0];
        REG_BINS_BEFORE:   cfg.bins_before   <= cfg_data[BEFORE_W-1:0];
        REG_BINS_AFTER:    cfg.bins_after    <= cfg_data[AFTER_W-1:0];
        REG_FLAG_POSITIVE: cfg.flag_positive <= cfg_data[0];
        REG_FLAG_NEGATIVE: cfg.flag_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  trm_front #(
    .MAX_BEFORE (MAX_BEFORE),
    .INDEX_BITS (INDEX_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_wdata),
    .job_full (job_full)
  );

  trm_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_wdata),
    .full      (job_full),
    .pop       (job_pop),
    .head_data (job_rdata),
    .not_empty (job_valid)
  );

  trm_back #(
    .MAX_BEFORE (MAX_BEFORE),
    .INDEX_BITS (INDEX_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_data  (job_rdata),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
